// ----- hdl/bis_pkg.sv -----
// Shared types and constants for the binary insertion sorter.
// Depends on nothing; every other file of the block imports it.
package bis_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // latch an input word and start the search bounds
    logic step;     // one binary search step
    logic insert;   // shift larger entries up and write the value
    logic emit;     // load the next sorted entry into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic search_done;  // search bounds have met
    logic last;         // the word being inserted closes the set
    logic emit_final;   // the entry being emitted is the largest one
    logic out_free;     // output register can take a new word
  } status_t;

endpackage

// ----- hdl/binary_insertion_sorter.sv -----
// Top level of the binary insertion sorter.
// Depends on bis_pkg, bis_ctrl and bis_datapath.

// Stable binary insertion sort over a stream of signed 32-bit words. Each
// input word is inserted into a store of 32 entries: a binary search finds
// the place after every stored entry that is less than or equal to it, and
// the larger entries all move up by one place at once. A word that carries
// in_tlast closes the set: after its insertion the whole set streams out in
// ascending order, one word per cycle while out_tready stays high, with
// out_tlast on the largest entry. Words that arrive while the store is full
// are dropped, and out_tuser is then 1 on every result of that set; the
// count and this flag clear once the last result is loaded into the output
// register. An input word is accepted, then searched by binary search steps
// and then inserted. A store of 31 entries is the largest one that still
// takes a word; the search loop makes one compare against the store per
// cycle. A full store skips the search, so a dropped word goes straight
// from accept to the insert step, which leaves the store as it is. A new
// input word is accepted as soon as the last result of a set sits in the
// output register.
module binary_insertion_sorter (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value (signed)
  input  logic        in_tlast,   // last word of the set
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value (signed)
  output logic        out_tlast,  // final_res: largest entry of the set
  output logic [0:0]  out_tuser   // [0] overflow
);
  import bis_pkg::*;

  cmd_t    cmd;
  status_t status;
  value_t  out_value;
  logic    out_overflow;

  bis_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  bis_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_value     (value_t'(in_tdata)),
    .in_last      (in_tlast),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_value    (out_value),
    .out_final    (out_tlast),
    .out_overflow (out_overflow)
  );

  assign out_tdata    = out_value;
  assign out_tuser[0] = out_overflow;

endmodule

// ----- hdl/bis_ctrl.sv -----
// Controller state machine of the binary insertion sorter.
// Depends on bis_pkg for the state, command and status types.
module bis_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  bis_pkg::status_t status,
  output bis_pkg::cmd_t    cmd
);
  import bis_pkg::*;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.search_done) begin
          cmd.insert = 1'b1;
          state_nxt  = status.last ? ST_EMIT : ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.emit_final) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/bis_datapath.sv -----
// Datapath of the binary insertion sorter: sorted store, search bounds,
// counters and the output register. Depends on bis_pkg.
module bis_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  bis_pkg::cmd_t    cmd,
  output bis_pkg::status_t status,
  input  bis_pkg::value_t  in_value,
  input  logic             in_last,
  input  logic             out_ready,
  output logic             out_valid,
  output bis_pkg::value_t  out_value,
  output logic             out_final,
  output logic             out_overflow
);
  import bis_pkg::*;

  value_t store_r [CAPACITY];
  value_t store_nxt [CAPACITY];

  value_t value_r;
  logic   last_r;
  cnt_t   count_r, count_nxt;
  logic   overflow_r, overflow_nxt;
  cnt_t   lo_r, lo_nxt, hi_r, hi_nxt;
  idx_t   emit_idx_r, emit_idx_nxt;

  logic   out_valid_r, out_valid_nxt;
  value_t out_value_r;
  logic   out_final_r, out_overflow_r;

  logic                full;
  logic [CNT_W:0]      bound_sum;
  idx_t                mid;
  idx_t                rd_idx;
  value_t              rd_data;
  logic                emit_final;
  idx_t                pos;

  assign full      = (count_r == cnt_t'(CAPACITY));
  assign bound_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = bound_sum[IDX_W:1];
  assign pos       = lo_r[IDX_W-1:0];

  // One read port serves both the search and the emit sweep.
  assign rd_idx  = cmd.emit ? emit_idx_r : mid;
  assign rd_data = store_r[rd_idx];

  assign emit_final = ((cnt_t'(emit_idx_r) + cnt_t'(1)) == count_r);

  assign status.search_done = (lo_r == hi_r);
  assign status.last        = last_r;
  assign status.emit_final  = emit_final;
  assign status.out_free    = !out_valid_r || out_ready;

  always_comb begin
    count_nxt    = count_r;
    overflow_nxt = overflow_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    emit_idx_nxt = emit_idx_r;
    if (cmd.accept) begin
      lo_nxt       = '0;
      // A full store skips the search; the word is dropped.
      hi_nxt       = full ? cnt_t'(0) : count_r;
      emit_idx_nxt = '0;
      if (full) begin
        overflow_nxt = 1'b1;
      end
    end
    if (cmd.step) begin
      if (value_r < rd_data) begin
        hi_nxt = cnt_t'(mid);
      end else begin
        lo_nxt = cnt_t'(mid) + cnt_t'(1);
      end
    end
    if (cmd.insert && !full) begin
      count_nxt = count_r + cnt_t'(1);
    end
    if (cmd.emit) begin
      emit_idx_nxt = emit_idx_r + idx_t'(1);
      if (emit_final) begin
        count_nxt    = '0;
        overflow_nxt = 1'b0;
      end
    end
  end

  // Insert: entries at or above the position move up by one place.
  always_comb begin
    for (int k = 0; k < CAPACITY; k++) begin
      store_nxt[k] = store_r[k];
      if (cmd.insert && !full) begin
        if (idx_t'(k) == pos) begin
          store_nxt[k] = value_r;
        end else if (k > 0 && idx_t'(k) > pos && cnt_t'(k) <= count_r) begin
          store_nxt[k] = store_r[(k > 0) ? k - 1 : 0];
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < CAPACITY; k++) begin
      store_r[k] <= store_nxt[k];
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    emit_idx_r <= emit_idx_nxt;
    if (cmd.accept) begin
      value_r <= in_value;
      last_r  <= in_last;
    end
    if (cmd.emit) begin
      out_value_r    <= rd_data;
      out_final_r    <= emit_final;
      out_overflow_r <= overflow_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      overflow_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      overflow_r  <= overflow_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_final    = out_final_r;
  assign out_overflow = out_overflow_r;

endmodule
